@@ hdl/bpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded positional list package
// Shared types, command codes and constants for the list unit and its cells.
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam int unsigned LIST_ENTRIES = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 4;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned CNT_OUT_W    = 5;
  // wide enough for positions and counts up to the largest list (256)
  localparam int unsigned LIST_PW      = 9;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT       = 4'd0,
    K_INSERT_FRONT = 4'd1,
    K_INSERT_BACK  = 4'd2,
    K_REMOVE       = 4'd3,
    K_REMOVE_FRONT = 4'd4,
    K_REMOVE_BACK  = 4'd5,
    K_READ         = 4'd6,
    K_SEARCH       = 4'd7,
    K_REPLACE      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_PUT,
    CELL_SRCH
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_e;

  typedef struct packed {
    cell_op_e                  op;
    logic [LIST_PW-1:0]        pos;
    logic [LIST_PW-1:0]        count;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

@@ hdl/bpl_cell.sv @@
// ----------------------------------------------------------------------------
// List cell
// Holds one entry; shifts toward or away from its neighbors on insert and
// remove, takes a new word on insert or replace, and flags a search match.
// ----------------------------------------------------------------------------
module bpl_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                              clk_i,
  input  bpl_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [bpl_pkg::DATA_W-1:0] prev_i,
  input  logic signed [bpl_pkg::DATA_W-1:0] next_i,
  output logic signed [bpl_pkg::DATA_W-1:0] data_o,
  output logic                              match_o
);
  import bpl_pkg::*;

  localparam logic [LIST_PW-1:0] MY_IDX = LIST_PW'(IDX);

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     match_q, match_d;

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (MY_IDX > ctrl_i.pos) begin
          data_d = prev_i;
        end else if (MY_IDX == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_REM: begin
        if (MY_IDX >= ctrl_i.pos) begin
          data_d = next_i;
        end
      end
      CELL_PUT: begin
        if (MY_IDX == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_SRCH: begin
        match_d = (MY_IDX < ctrl_i.count) && (data_q == ctrl_i.value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

@@ hdl/bpl_first_match.sv @@
// ----------------------------------------------------------------------------
// First match encoder
// Gives the lowest cell index whose match flag is set.
// ----------------------------------------------------------------------------
module bpl_first_match #(
  parameter int unsigned ENTRIES = bpl_pkg::LIST_ENTRIES
) (
  input  logic [ENTRIES-1:0]               match_i,
  output logic                             hit_o,
  output logic [bpl_pkg::LIST_PW-1:0]      index_o
);
  import bpl_pkg::*;

  always_comb begin
    index_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        index_o = LIST_PW'(i);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

@@ hdl/bounded_positional_list_unit.sv @@
// ----------------------------------------------------------------------------
// Bounded positional list unit
// Ordered list of up to ENTRIES signed words with indexed insert and remove.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel: kind in tuser, position and value in
// tdata. Each command gives exactly one result on the m_axis channel with
// ok, read data, search position, count and the empty and full flags.
// The list lives in a row of cells, one entry per cell; insert and remove
// shift every affected cell together by one place toward its neighbor,
// and search compares all cells at once.
// An item passes the idle, execute and finish states: idle registers the
// command, execute lets the cells shift or compare and the read mux sample,
// and finish lets the first match encoder settle and the result register
// load. One item is in flight at a time; the next is taken back in idle.
// The result register parts the two sides: a new command is taken while a
// result still waits, and when the receiver stalls the next result holds in
// its last stage until the register frees up.
// Reset empties the list at once (count zero); cell contents are not cleared
// and are never read before they are written.
// ----------------------------------------------------------------------------
module bounded_positional_list_unit #(
  parameter int unsigned ENTRIES = bpl_pkg::LIST_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero fill
  input  logic [3:0]  s_axis_tuser,   // kind[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok[0], read_value[32:1], found_at[37:33],
                                      // count[42:38], is_empty[43], is_full[44]
);
  import bpl_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [LIST_PW-1:0] CAP = LIST_PW'(ENTRIES);

  state_e state_q, state_d;
  logic   exec_en, fin_en, accept;

  logic [KIND_W-1:0]        kind_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] value_q;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     res_ok_q, res_ok_d;
  logic signed [DATA_W-1:0] res_rd_q, res_rd_d;
  logic                     res_srch_q;

  logic                     out_valid_q;
  logic                     out_ok_q;
  logic signed [DATA_W-1:0] out_rd_q;
  logic [CNT_OUT_W-1:0]     out_found_q, out_cnt_q;
  logic                     out_empty_q, out_full_q;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_data [ENTRIES];
  logic [ENTRIES-1:0]       cell_match;
  logic                     hit;
  logic [LIST_PW-1:0]       hit_idx;

  logic [LIST_PW-1:0] cnt_w, pos_w, ins_pos, rem_pos, rd_idx;
  logic               ins_ok, rem_ok, pos_in;

  // ---------------- control FSM ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_FIN;
      ST_FIN:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    exec_en       = 1'b0;
    fin_en        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_en = 1'b1;
      ST_FIN:  fin_en = !out_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= s_axis_tuser;
      pos_q   <= s_axis_tdata[4:0];
      value_q <= s_axis_tdata[36:5];
    end
  end

  // ---------------- command decode ----------------
  assign cnt_w  = LIST_PW'(cnt_q);
  assign pos_w  = LIST_PW'(pos_q);
  assign pos_in = pos_w < cnt_w;

  always_comb begin
    ins_pos = pos_w;
    rem_pos = pos_w;
    case (kind_q)
      K_INSERT_FRONT: ins_pos = '0;
      K_INSERT_BACK:  ins_pos = cnt_w;
      K_REMOVE_FRONT: rem_pos = '0;
      K_REMOVE_BACK:  rem_pos = cnt_w - LIST_PW'(1);
      default: begin
      end
    endcase
  end

  assign ins_ok = (cnt_w < CAP) && (ins_pos <= cnt_w);
  assign rem_ok = (cnt_w != '0) && (rem_pos < cnt_w);
  assign rd_idx = pos_in ? pos_w : cnt_w - LIST_PW'(1);

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = pos_w;
    ctrl.count = cnt_w;
    ctrl.value = value_q;
    cnt_d      = cnt_q;
    res_ok_d   = 1'b0;
    res_rd_d   = '0;
    if (exec_en) begin
      case (kind_q) inside
        K_INSERT, K_INSERT_FRONT, K_INSERT_BACK: begin
          ctrl.pos = ins_pos;
          res_ok_d = ins_ok;
          if (ins_ok) begin
            ctrl.op = CELL_INS;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        K_REMOVE, K_REMOVE_FRONT, K_REMOVE_BACK: begin
          ctrl.pos = rem_pos;
          res_ok_d = rem_ok;
          if (rem_ok) begin
            ctrl.op = CELL_REM;
            cnt_d   = cnt_q - CNT_W'(1);
          end
        end
        K_READ: begin
          res_ok_d = pos_in;
          if (cnt_w != '0) begin
            res_rd_d = cell_data[rd_idx[IDX_W-1:0]];
          end
        end
        K_SEARCH: begin
          ctrl.op = CELL_SRCH;
        end
        K_REPLACE: begin
          res_ok_d = pos_in;
          if (pos_in) begin
            ctrl.op = CELL_PUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      res_ok_q   <= res_ok_d;
      res_rd_q   <= res_rd_d;
      res_srch_q <= (kind_q == K_SEARCH);
    end
  end

  // ---------------- cell row ----------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = value_q;
    end else begin : g_mid
      assign prev = cell_data[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_inner
      assign next = cell_data[i+1];
    end
    bpl_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .next_i  (next),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );
  end

  bpl_first_match #(
    .ENTRIES (ENTRIES)
  ) u_first_match (
    .match_i (cell_match),
    .hit_o   (hit),
    .index_o (hit_idx)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_ok_q    <= res_srch_q ? hit : res_ok_q;
      out_rd_q    <= res_rd_q;
      out_found_q <= !res_srch_q ? '0 :
                     hit ? CNT_OUT_W'(hit_idx) : CNT_OUT_W'(cnt_q);
      out_cnt_q   <= CNT_OUT_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
      out_full_q  <= (cnt_w == CAP);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_full_q, out_empty_q, out_cnt_q, out_found_q,
                          out_rd_q, out_ok_q};

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIST_PW'(cnt_q) <= CAP)
    else $error("list count above capacity");

  a_cnt_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EXEC) |=> $stable(cnt_q))
    else $error("list count changed outside execute");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not execute");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !m_axis_tready) |=> (state_q == ST_FIN))
    else $error("result dropped during stall");

endmodule

@@ tb/sv/bounded_positional_list_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Bounded positional list unit testbench
// Drives list commands on the input stream and checks every result item
// against an in-bench list predictor. A directed table covers the empty and
// full extremes, each command and every reject case, then random traffic
// (biased to fill and drain the list) runs under several idle/stall mixes.
// ----------------------------------------------------------------------------
module bounded_positional_list_unit_tb;

  import bpl_pkg::*;

  localparam int unsigned        CAPACITY       = LIST_ENTRIES;
  localparam logic [KIND_W-1:0]  KIND_BAD_MIN   = KIND_W'(K_REPLACE) + KIND_W'(1);
  localparam logic [KIND_W-1:0]  KIND_BAD_MAX   = {KIND_W{1'b1}};
  localparam int unsigned        RAND_PER_PHASE = 280;
  localparam int unsigned        CYCLE_LIMIT    = 200000;
  localparam int unsigned        MAX_REPORTS    = 10;

  typedef struct packed {
    logic                ok;
    logic [DATA_W-1:0]   rd;
    logic [POS_W-1:0]    found;
    logic [CNT_OUT_W-1:0] count;
    logic                empty;
    logic                full;
  } list_result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
    int unsigned        rep;
    bit                 typed;
    list_result_t       res;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata   = '0;
  logic [3:0]  s_axis_tuser   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [47:0] m_axis_tdata;

  bounded_positional_list_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // list shadow
  logic [DATA_W-1:0] shadow_words [CAPACITY];
  int unsigned       shadow_len = 0;
  bit                grow       = 1'b1;

  list_result_t pending_results[$];
  int unsigned  mismatches  = 0;
  int unsigned  cycles      = 0;
  int unsigned  src_idle_pct  = 0;
  int unsigned  sink_stall_pct = 0;

  function automatic bit list_put(int unsigned pos, logic [DATA_W-1:0] val);
    int unsigned i;
    if (shadow_len >= CAPACITY || pos > shadow_len) return 1'b0;
    for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = val;
    shadow_len++;
    return 1'b1;
  endfunction

  function automatic bit list_take(int unsigned pos);
    int unsigned i;
    if (pos >= shadow_len) return 1'b0;
    for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
    shadow_len--;
    return 1'b1;
  endfunction

  function automatic list_result_t apply_command(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    bit           hit;
    r   = '0;
    hit = 1'b0;
    case (kind)
      K_INSERT:       r.ok = list_put(32'(pos), val);
      K_INSERT_FRONT: r.ok = list_put(0, val);
      K_INSERT_BACK:  r.ok = list_put(shadow_len, val);
      K_REMOVE:       r.ok = list_take(32'(pos));
      K_REMOVE_FRONT: r.ok = list_take(0);
      K_REMOVE_BACK: begin
        if (shadow_len != 0) r.ok = list_take(shadow_len - 1);
      end
      K_READ: begin
        if (pos < shadow_len) begin
          r.ok = 1'b1;
          r.rd = shadow_words[pos];
        end else if (shadow_len != 0) begin
          r.rd = shadow_words[shadow_len-1];
        end
      end
      K_SEARCH: begin
        r.found = POS_W'(shadow_len);
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_words[i] == val) begin
            hit     = 1'b1;
            r.found = POS_W'(i);
            r.ok    = 1'b1;
          end
        end
      end
      K_REPLACE: begin
        if (pos < shadow_len) begin
          shadow_words[pos] = val;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = CNT_OUT_W'(shadow_len);
    r.empty = (shadow_len == 0);
    r.full  = (shadow_len == CAPACITY);
    return r;
  endfunction

  task automatic send_command(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [DATA_W-1:0] val, bit typed,
                              list_result_t typed_res);
    list_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, val, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_command(kind, pos, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  function automatic cmd_row_t mk_row(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                      logic [DATA_W-1:0] val, int unsigned rep, bit typed,
                                      logic ok, logic [DATA_W-1:0] rd,
                                      logic [POS_W-1:0] found, logic [CNT_OUT_W-1:0] cnt);
    cmd_row_t row;
    row.kind      = kind;
    row.pos       = pos;
    row.value     = val;
    row.rep       = rep;
    row.typed     = typed;
    row.res.ok    = ok;
    row.res.rd    = rd;
    row.res.found = found;
    row.res.count = cnt;
    row.res.empty = (cnt == 0);
    row.res.full  = (cnt == CAPACITY);
    return row;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(bit for_search);
    int unsigned roll;
    roll = $urandom_range(99);
    if (for_search && shadow_len != 0 && roll < 50)
      return shadow_words[$urandom_range(shadow_len - 1)];
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4: return DATA_W'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int unsigned       roll;
    int unsigned       ins_w;
    int unsigned       rem_w;
    if (shadow_len == CAPACITY) grow = 1'b0;
    if (shadow_len == 0) grow = 1'b1;
    ins_w = grow ? 50 : 15;
    rem_w = grow ? 15 : 45;
    roll  = $urandom_range(99);
    if (roll < 4) begin
      kind = KIND_W'($urandom_range(KIND_BAD_MIN, KIND_BAD_MAX));
      pos  = POS_W'($urandom);
      val  = $urandom;
    end else if (roll < 14) begin
      kind = KIND_W'($urandom_range(K_INSERT, K_REPLACE));
      pos  = POS_W'($urandom);
      val  = pick_value(1'b0);
    end else begin
      roll = $urandom_range(99);
      if (roll < ins_w) begin
        kind = KIND_W'($urandom_range(K_INSERT, K_INSERT_BACK));
        pos  = POS_W'($urandom_range(shadow_len));
      end else if (roll < ins_w + rem_w) begin
        kind = KIND_W'($urandom_range(K_REMOVE, K_REMOVE_BACK));
        pos  = shadow_len != 0 ? POS_W'($urandom_range(shadow_len - 1)) : '0;
      end else begin
        kind = KIND_W'($urandom_range(K_READ, K_REPLACE));
        pos  = shadow_len != 0 ? POS_W'($urandom_range(shadow_len - 1)) : '0;
      end
      val = pick_value(kind == K_SEARCH);
    end
    send_command(kind, pos, val, 1'b0, '0);
  endtask

  // result side: random stall, compare against oldest expectation
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok    = m_axis_tdata[0];
      got.rd    = m_axis_tdata[32:1];
      got.found = m_axis_tdata[37:33];
      got.count = m_axis_tdata[42:38];
      got.empty = m_axis_tdata[43];
      got.full  = m_axis_tdata[44];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.rd !== want.rd || got.found !== want.found ||
            got.count !== want.count || got.empty !== want.empty ||
            got.full !== want.full) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %p, actual %p", want, got);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("** bounded_positional_list_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cmd_row_t    rows[$];
    int unsigned idle_mix[4][2];
    idle_mix = '{'{0, 0}, '{72, 0}, '{0, 72}, '{25, 25}};

    rows.push_back(mk_row(K_READ,         0,  32'h0,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REMOVE_FRONT, 0,  32'h0,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REMOVE_BACK,  0,  32'h0,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REMOVE,       0,  32'h0,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_SEARCH,       0,  32'h5,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REPLACE,      0,  32'h1,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_INSERT,       1,  32'h1,         1, 1, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_INSERT,       0,  32'h7FFF_FFFF, 1, 1, 1, 32'h0,         0, 1));
    rows.push_back(mk_row(K_INSERT_FRONT, 0,  32'h8000_0000, 1, 1, 1, 32'h0,         0, 2));
    rows.push_back(mk_row(K_INSERT_BACK,  0,  32'h0,         1, 1, 1, 32'h0,         0, 3));
    rows.push_back(mk_row(K_INSERT,       1,  32'hFFFF_FFFF, 1, 1, 1, 32'h0,         0, 4));
    rows.push_back(mk_row(K_READ,         2,  32'h0,         1, 1, 1, 32'h7FFF_FFFF, 0, 4));
    rows.push_back(mk_row(K_READ,         31, 32'h0,         1, 1, 0, 32'h0,         0, 4));
    rows.push_back(mk_row(K_SEARCH,       0,  32'h7FFF_FFFF, 1, 1, 1, 32'h0,         2, 4));
    rows.push_back(mk_row(K_SEARCH,       0,  32'h0001_2345, 1, 1, 0, 32'h0,         4, 4));
    rows.push_back(mk_row(K_REPLACE,      3,  32'hA5A5_A5A5, 1, 1, 1, 32'h0,         0, 4));
    rows.push_back(mk_row(K_REPLACE,      4,  32'h5A5A_5A5A, 1, 1, 0, 32'h0,         0, 4));
    rows.push_back(mk_row(K_REMOVE,       1,  32'h0,         1, 0, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(KIND_BAD_MIN,   0,  32'h0,         1, 1, 0, 32'h0,         0, 3));
    rows.push_back(mk_row(KIND_BAD_MAX,   31, 32'hFFFF_FFFF, 1, 1, 0, 32'h0,         0, 3));
    rows.push_back(mk_row(K_INSERT_BACK,  0,  32'h0000_0100, 13, 0, 0, 32'h0,        0, 0));
    rows.push_back(mk_row(K_INSERT_FRONT, 0,  32'h1,         1, 1, 0, 32'h0,         0, 16));
    rows.push_back(mk_row(K_INSERT,       5,  32'h1,         1, 1, 0, 32'h0,         0, 16));
    rows.push_back(mk_row(K_INSERT,       16, 32'h1,         1, 1, 0, 32'h0,         0, 16));
    rows.push_back(mk_row(K_REMOVE,       16, 32'h0,         1, 1, 0, 32'h0,         0, 16));
    rows.push_back(mk_row(K_REMOVE,       15, 32'h0,         1, 0, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REMOVE_BACK,  0,  32'h0,         1, 0, 0, 32'h0,         0, 0));
    rows.push_back(mk_row(K_REMOVE_FRONT, 0,  32'h0,         1, 0, 0, 32'h0,         0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      for (int unsigned i = 0; i < rows[r].rep; i++)
        send_command(rows[r].kind, rows[r].pos, rows[r].value + i, rows[r].typed,
                     rows[r].res);
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_mix[p][0];
      sink_stall_pct = idle_mix[p][1];
      repeat (RAND_PER_PHASE) send_random();
    end
    s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** bounded_positional_list_unit: PASSED **");
    end else begin
      $display("** bounded_positional_list_unit: FAILED **");
    end
    $finish;
  end

endmodule
